@@ hdl/salc_pkg.sv @@
// package for the set-associative lru cache lookup block
// shared constants, configuration register codes, back-end state type
// no dependencies
package salc_pkg;

  // default geometry limits
  localparam int unsigned MAX_SETS_DEF  = 256;
  localparam int unsigned MAX_WAYS_DEF  = 8;
  localparam int unsigned ADDR_BITS_DEF = 32;

  // fixed field widths
  localparam int unsigned IN_ADDR_W    = 32;
  localparam int unsigned CFG_VAL_W    = 4;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned WAY_FIELD_W  = 3;
  localparam int unsigned OUT_DATA_W   = 72;
  localparam int unsigned OFFSET_LIMIT = 12;
  localparam int unsigned STAMP_W      = CNT_W;

  // front-to-back queue depth
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS    = 2'd0,
    CFG_SET_INDEX_BITS = 2'd1,
    CFG_WAY_COUNT      = 2'd2
  } cfg_reg_e;

  // configuration register contents
  typedef struct packed {
    logic [CFG_VAL_W-1:0] offset_bits;
    logic [CFG_VAL_W-1:0] set_index_bits;
    logic [CFG_VAL_W-1:0] way_count;
  } cfg_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EVAL
  } bk_state_e;

endpackage

@@ hdl/set_assoc_lru_cache_lookup.sv @@
// top level of the set-associative cache lookup with lru replacement
// depends on salc_pkg, salc_front, salc_queue, salc_back
//
//  channel   direction  handshake                      payload
//  --------  ---------  -----------------------------  -------------------------------
//  s_axis    in         s_axis_tvalid_i/tready_o       tdata: address
//  m_axis    out        m_axis_tvalid_o/tready_i       tdata: hit, way, evicted, totals
//  cfg       in         cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// the back end reads the set row of each word from the set memory, then decides
// hit/fill/lru victim and writes the row back once the output register is free;
// only then does it take a new word. the front end takes words into a 2-entry
// queue, so it accepts words while the back end or the output waits, until full.
// after reset the back end clears all 2**floor(log2 MAX_SETS) rows (256 at default)
// one row per cycle, with s_axis_tready_o low; cfg writes are taken at all times.
// an unaccepted result stalls the back end, and the front end once the queue is full.
module set_assoc_lru_cache_lookup #(
  parameter int unsigned MAX_SETS  = salc_pkg::MAX_SETS_DEF,
  parameter int unsigned MAX_WAYS  = salc_pkg::MAX_WAYS_DEF,
  parameter int unsigned ADDR_BITS = salc_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [salc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [salc_pkg::CFG_VAL_W-1:0]    cfg_data_i,
  // address words
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [salc_pkg::IN_ADDR_W-1:0]    s_axis_tdata_i,  // [31:0] address
  // result words
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [0] hit, [3:1] way_used, [4] evicted, [36:5] access_total,
  // [68:37] hit_total, [71:69] zero
  output logic [salc_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  // set index and tag widths follow from the geometry limits
  localparam int unsigned IDX_LIM = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned SET_W   = (IDX_LIM > 0) ? IDX_LIM : 1;
  localparam int unsigned TAG_W   = (ADDR_BITS < salc_pkg::IN_ADDR_W) ?
                                    ADDR_BITS : salc_pkg::IN_ADDR_W;
  localparam int unsigned Q_W     = TAG_W + SET_W;

  salc_pkg::cfg_t   cfg;
  logic             init_done;
  logic             q_full;
  logic             q_push;
  logic [Q_W-1:0]   q_wdata;
  logic             q_valid;
  logic             q_pop;
  logic [Q_W-1:0]   q_rdata;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  // front: config registers, address split into {tag, set}
  salc_front #(
    .MAX_SETS  (MAX_SETS),
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .s_valid_i   (s_axis_tvalid_i),
    .s_addr_i    (s_axis_tdata_i),
    .s_ready_o   (s_axis_tready_o),
    .init_done_i (init_done),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  // decoupling queue
  salc_queue #(
    .WIDTH (Q_W),
    .DEPTH (salc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  // back: set lookup, replacement, counters, output register
  salc_back #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .way_count_i (cfg.way_count),
    .init_done_o (init_done),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (m_axis_tdata_o)
  );

endmodule

@@ hdl/salc_queue.sv @@
// small fifo between the address front end and the lookup back end
// depends on salc_pkg
module salc_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = salc_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hdl/salc_front.sv @@
// front end: configuration registers and address split into set and tag
// depends on salc_pkg
module salc_front #(
  parameter int unsigned MAX_SETS  = salc_pkg::MAX_SETS_DEF,
  parameter int unsigned ADDR_BITS = salc_pkg::ADDR_BITS_DEF,
  localparam int unsigned IDX_LIM  = $clog2(MAX_SETS + 1) - 1,
  localparam int unsigned SET_W    = (IDX_LIM > 0) ? IDX_LIM : 1,
  localparam int unsigned TAG_W    = (ADDR_BITS < salc_pkg::IN_ADDR_W) ?
                                     ADDR_BITS : salc_pkg::IN_ADDR_W
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_valid_i,
  input  logic [salc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [salc_pkg::CFG_VAL_W-1:0]      cfg_data_i,
  output salc_pkg::cfg_t                      cfg_o,
  // address stream
  input  logic                                s_valid_i,
  input  logic [salc_pkg::IN_ADDR_W-1:0]      s_addr_i,
  output logic                                s_ready_o,
  // queue side
  input  logic                                init_done_i,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output logic [TAG_W+SET_W-1:0]              q_data_o
);

  localparam int unsigned SH_W = 6;

  salc_pkg::cfg_t           cfg_q, cfg_d;
  logic [salc_pkg::CFG_VAL_W-1:0] off_eff;
  logic [salc_pkg::CFG_VAL_W-1:0] idx_eff;
  logic [TAG_W-1:0]         addr_m;
  logic [TAG_W-1:0]         addr_sh;
  logic [TAG_W-1:0]         tag;
  logic [SET_W-1:0]         set_mask;
  logic [SET_W-1:0]         set_sel;
  logic [SH_W-1:0]          tag_sh;

  // config register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        salc_pkg::CFG_OFFSET_BITS:    cfg_d.offset_bits    = cfg_data_i;
        salc_pkg::CFG_SET_INDEX_BITS: cfg_d.set_index_bits = cfg_data_i;
        salc_pkg::CFG_WAY_COUNT:      cfg_d.way_count      = cfg_data_i;
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_bits    <= salc_pkg::CFG_VAL_W'(4);
      cfg_q.set_index_bits <= salc_pkg::CFG_VAL_W'(6);
      cfg_q.way_count      <= salc_pkg::CFG_VAL_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  // clamp geometry, split the address
  always_comb begin
    off_eff = (cfg_q.offset_bits > salc_pkg::CFG_VAL_W'(salc_pkg::OFFSET_LIMIT)) ?
              salc_pkg::CFG_VAL_W'(salc_pkg::OFFSET_LIMIT) : cfg_q.offset_bits;
    idx_eff = (cfg_q.set_index_bits > salc_pkg::CFG_VAL_W'(IDX_LIM)) ?
              salc_pkg::CFG_VAL_W'(IDX_LIM) : cfg_q.set_index_bits;
    addr_m   = s_addr_i[TAG_W-1:0];
    addr_sh  = addr_m >> off_eff;
    set_mask = ~({SET_W{1'b1}} << idx_eff);
    set_sel  = addr_sh[SET_W-1:0] & set_mask;
    tag_sh   = SH_W'(off_eff) + SH_W'(idx_eff);
    tag      = addr_m >> tag_sh;
  end

  assign s_ready_o = init_done_i && !q_full_i;
  assign q_push_o  = s_valid_i && s_ready_o;
  assign q_data_o  = {tag, set_sel};

endmodule

@@ hdl/salc_back.sv @@
// back end: set memory, hit/fill/lru decision, write-back, counters, result register
// depends on salc_pkg
module salc_back #(
  parameter int unsigned MAX_SETS  = salc_pkg::MAX_SETS_DEF,
  parameter int unsigned MAX_WAYS  = salc_pkg::MAX_WAYS_DEF,
  parameter int unsigned ADDR_BITS = salc_pkg::ADDR_BITS_DEF,
  localparam int unsigned IDX_LIM  = $clog2(MAX_SETS + 1) - 1,
  localparam int unsigned SET_W    = (IDX_LIM > 0) ? IDX_LIM : 1,
  localparam int unsigned TAG_W    = (ADDR_BITS < salc_pkg::IN_ADDR_W) ?
                                     ADDR_BITS : salc_pkg::IN_ADDR_W
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [salc_pkg::CFG_VAL_W-1:0]     way_count_i,
  output logic                               init_done_o,
  // queue side
  input  logic                               q_valid_i,
  input  logic [TAG_W+SET_W-1:0]             q_data_i,
  output logic                               q_pop_o,
  // result stream
  output logic                               m_valid_o,
  input  logic                               m_ready_i,
  output logic [salc_pkg::OUT_DATA_W-1:0]    m_data_o
);

  localparam int unsigned SET_DEPTH = 1 << IDX_LIM;
  localparam int unsigned WAY_IW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned LEAF_N    = 1 << WAY_IW;
  localparam int unsigned NODE_N    = 2 * LEAF_N - 1;
  localparam int unsigned SW        = salc_pkg::STAMP_W;
  localparam int unsigned WAY_W     = 1 + TAG_W + SW;
  localparam int unsigned ROW_W     = MAX_WAYS * WAY_W;
  localparam int unsigned CW        = salc_pkg::CNT_W;
  localparam int unsigned VW        = salc_pkg::CFG_VAL_W;

  // set memory, one row per set: per way {stamp, tag, valid}
  logic [ROW_W-1:0] mem_q [SET_DEPTH];
  logic [ROW_W-1:0] rd_q;
  logic             mem_re, mem_we;
  logic [SET_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;

  salc_pkg::bk_state_e state_q, state_d;
  logic [SET_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [SET_W-1:0] cur_set_q;
  logic [TAG_W-1:0] cur_tag_q;
  logic [CW-1:0]    acc_q, acc_d;
  logic [CW-1:0]    hits_q, hits_d;
  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic             out_free;

  logic                       res_hit_q;
  logic [WAY_IW-1:0]          res_way_q;
  logic                       res_evict_q;
  logic [CW-1:0]              res_acc_q;
  logic [CW-1:0]              res_hits_q;

  // lookup datapath
  logic [VW-1:0]     ways_eff;
  logic [MAX_WAYS-1:0] way_en, way_vld, hit_vec, free_vec;
  logic [TAG_W-1:0]  way_tag   [MAX_WAYS];
  logic [SW-1:0]     way_stamp [MAX_WAYS];
  logic [WAY_IW-1:0] hit_way, free_way, lru_way, pick;
  logic              is_hit, has_free;
  logic [CW-1:0]     acc_inc;
  logic [ROW_W-1:0]  new_row;
  logic              nd_en    [NODE_N];
  logic [SW-1:0]     nd_stamp [NODE_N];
  logic [WAY_IW-1:0] nd_idx   [NODE_N];

  always_comb begin
    ways_eff = (way_count_i == '0) ? VW'(1) : way_count_i;
    if (ways_eff > VW'(MAX_WAYS)) begin
      ways_eff = VW'(MAX_WAYS);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_en[w]    = (VW'(w) < ways_eff);
      way_vld[w]   = rd_q[w*WAY_W];
      way_tag[w]   = rd_q[w*WAY_W+1 +: TAG_W];
      way_stamp[w] = rd_q[w*WAY_W+1+TAG_W +: SW];
      hit_vec[w]   = way_en[w] && way_vld[w] && (way_tag[w] == cur_tag_q);
      free_vec[w]  = way_en[w] && !way_vld[w];
    end
  end

  // first hitting way and first free way
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_IW'(w);
      end
      if (free_vec[w]) begin
        free_way = WAY_IW'(w);
      end
    end
    is_hit   = |hit_vec;
    has_free = |free_vec;
  end

  // lru tree: smallest stamp, lowest way on ties
  always_comb begin
    for (int i = 0; i < NODE_N; i++) begin
      nd_en[i]    = 1'b0;
      nd_stamp[i] = '0;
      nd_idx[i]   = '0;
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      nd_en[LEAF_N-1+w]    = way_en[w];
      nd_stamp[LEAF_N-1+w] = way_stamp[w];
      nd_idx[LEAF_N-1+w]   = WAY_IW'(w);
    end
    for (int i = LEAF_N - 2; i >= 0; i--) begin
      if (!nd_en[2*i+1] || (nd_en[2*i+2] && (nd_stamp[2*i+2] < nd_stamp[2*i+1]))) begin
        nd_en[i]    = nd_en[2*i+2];
        nd_stamp[i] = nd_stamp[2*i+2];
        nd_idx[i]   = nd_idx[2*i+2];
      end else begin
        nd_en[i]    = nd_en[2*i+1];
        nd_stamp[i] = nd_stamp[2*i+1];
        nd_idx[i]   = nd_idx[2*i+1];
      end
    end
    lru_way = nd_idx[0];
  end

  always_comb begin
    acc_inc = (acc_q == {CW{1'b1}}) ? acc_q : acc_q + CW'(1);
    pick    = is_hit ? hit_way : (has_free ? free_way : lru_way);
    new_row = rd_q;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (pick == WAY_IW'(w)) begin
        new_row[w*WAY_W +: WAY_W] = {acc_inc, cur_tag_q, 1'b1};
      end
    end
  end

  assign out_free = !out_valid_q || m_ready_i;

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    q_pop_o     = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cur_set_q;
    mem_wdata   = new_row;
    out_load    = 1'b0;
    case (state_q)
      salc_pkg::BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        if (clr_cnt_q == SET_W'(SET_DEPTH - 1)) begin
          state_d = salc_pkg::BK_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + SET_W'(1);
        end
      end
      salc_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          mem_re  = 1'b1;
          state_d = salc_pkg::BK_EVAL;
        end
      end
      salc_pkg::BK_EVAL: begin
        if (out_free) begin
          mem_we   = 1'b1;
          out_load = 1'b1;
          state_d  = salc_pkg::BK_IDLE;
        end
      end
      default: state_d = salc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    acc_d       = acc_q;
    hits_d      = hits_q;
    out_valid_d = out_valid_q && !m_ready_i;
    if (out_load) begin
      acc_d       = acc_inc;
      out_valid_d = 1'b1;
      if (is_hit && (hits_q != {CW{1'b1}})) begin
        hits_d = hits_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= salc_pkg::BK_CLEAR;
      clr_cnt_q   <= '0;
      acc_q       <= '0;
      hits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      acc_q       <= acc_d;
      hits_q      <= hits_d;
      out_valid_q <= out_valid_d;
    end
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[q_data_i[SET_W-1:0]];
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_set_q <= q_data_i[SET_W-1:0];
      cur_tag_q <= q_data_i[SET_W +: TAG_W];
    end
    if (out_load) begin
      res_hit_q   <= is_hit;
      res_way_q   <= pick;
      res_evict_q <= !is_hit && !has_free;
      res_acc_q   <= acc_inc;
      res_hits_q  <= hits_d;
    end
  end

  assign init_done_o = (state_q != salc_pkg::BK_CLEAR);
  assign m_valid_o   = out_valid_q;
  assign m_data_o    = {3'b000, res_hits_q, res_acc_q, res_evict_q,
                        salc_pkg::WAY_FIELD_W'(res_way_q), res_hit_q};

endmodule
